[src/rvic_pkg.sv]
`default_nettype none
package rvic_pkg;

  localparam int WORD_W = 32;
  localparam int ID_W   = 6;
  localparam int CLS_W  = 4;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [WORD_W-1:0] WORD_NOP = 32'h0000_0013;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_MUL  = 7'h01;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // Opcode classes
  localparam logic [CLS_W-1:0] CLS_NONE   = 4'd0;
  localparam logic [CLS_W-1:0] CLS_LUI    = 4'd1;
  localparam logic [CLS_W-1:0] CLS_AUIPC  = 4'd2;
  localparam logic [CLS_W-1:0] CLS_JAL    = 4'd3;
  localparam logic [CLS_W-1:0] CLS_JALR   = 4'd4;
  localparam logic [CLS_W-1:0] CLS_BRANCH = 4'd5;
  localparam logic [CLS_W-1:0] CLS_LOAD   = 4'd6;
  localparam logic [CLS_W-1:0] CLS_STORE  = 4'd7;
  localparam logic [CLS_W-1:0] CLS_SYSTEM = 4'd8;
  localparam logic [CLS_W-1:0] CLS_OPIMM  = 4'd9;
  localparam logic [CLS_W-1:0] CLS_OP     = 4'd10;

  // Instruction numbers
  localparam logic [ID_W-1:0] ID_NONE   = 6'd0;
  localparam logic [ID_W-1:0] ID_ADDI   = 6'd1;
  localparam logic [ID_W-1:0] ID_SLTI   = 6'd2;
  localparam logic [ID_W-1:0] ID_ANDI   = 6'd3;
  localparam logic [ID_W-1:0] ID_ORI    = 6'd4;
  localparam logic [ID_W-1:0] ID_XORI   = 6'd5;
  localparam logic [ID_W-1:0] ID_SLLI   = 6'd6;
  localparam logic [ID_W-1:0] ID_SRLI   = 6'd7;
  localparam logic [ID_W-1:0] ID_SRAI   = 6'd8;
  localparam logic [ID_W-1:0] ID_LUI    = 6'd9;
  localparam logic [ID_W-1:0] ID_AUIPC  = 6'd10;
  localparam logic [ID_W-1:0] ID_ADD    = 6'd11;
  localparam logic [ID_W-1:0] ID_SLT    = 6'd12;
  localparam logic [ID_W-1:0] ID_SLTU   = 6'd13;
  localparam logic [ID_W-1:0] ID_AND    = 6'd14;
  localparam logic [ID_W-1:0] ID_OR     = 6'd15;
  localparam logic [ID_W-1:0] ID_XOR    = 6'd16;
  localparam logic [ID_W-1:0] ID_SLL    = 6'd17;
  localparam logic [ID_W-1:0] ID_SRL    = 6'd18;
  localparam logic [ID_W-1:0] ID_SUB    = 6'd19;
  localparam logic [ID_W-1:0] ID_SLTIU  = 6'd20;
  localparam logic [ID_W-1:0] ID_SRA    = 6'd21;
  localparam logic [ID_W-1:0] ID_NOP    = 6'd22;
  localparam logic [ID_W-1:0] ID_JAL    = 6'd23;
  localparam logic [ID_W-1:0] ID_JALR   = 6'd24;
  localparam logic [ID_W-1:0] ID_BEQ    = 6'd25;
  localparam logic [ID_W-1:0] ID_BNE    = 6'd26;
  localparam logic [ID_W-1:0] ID_BLT    = 6'd27;
  localparam logic [ID_W-1:0] ID_BGE    = 6'd28;
  localparam logic [ID_W-1:0] ID_BLTU   = 6'd29;
  localparam logic [ID_W-1:0] ID_BGEU   = 6'd30;
  localparam logic [ID_W-1:0] ID_CSRRW  = 6'd31;
  localparam logic [ID_W-1:0] ID_CSRRS  = 6'd32;
  localparam logic [ID_W-1:0] ID_CSRRC  = 6'd33;
  localparam logic [ID_W-1:0] ID_LB     = 6'd40;
  localparam logic [ID_W-1:0] ID_LH     = 6'd41;
  localparam logic [ID_W-1:0] ID_LW     = 6'd42;
  localparam logic [ID_W-1:0] ID_LBU    = 6'd43;
  localparam logic [ID_W-1:0] ID_LHU    = 6'd44;
  localparam logic [ID_W-1:0] ID_SB     = 6'd45;
  localparam logic [ID_W-1:0] ID_SH     = 6'd46;
  localparam logic [ID_W-1:0] ID_SW     = 6'd47;
  localparam logic [ID_W-1:0] ID_MUL    = 6'd50;
  localparam logic [ID_W-1:0] ID_REM    = 6'd52;
  localparam logic [ID_W-1:0] ID_MULH   = 6'd53;
  localparam logic [ID_W-1:0] ID_MULHSU = 6'd54;
  localparam logic [ID_W-1:0] ID_MULHU  = 6'd55;

  typedef struct packed {
    logic             is_nop;
    logic [CLS_W-1:0] cls;
    logic [2:0]       f3;
    logic             f7_base;
    logic             f7_mul;
    logic             f7_alt;
  } fields_t;

  function automatic logic [ID_W-1:0] lookup_id(input fields_t d);
    logic [ID_W-1:0] id;
    id = ID_NONE;
    if (d.is_nop) begin
      id = ID_NOP;
    end else begin
      case (d.cls)
        CLS_LUI:   id = ID_LUI;
        CLS_AUIPC: id = ID_AUIPC;
        CLS_JAL:   id = ID_JAL;
        CLS_JALR:  id = (d.f3 == 3'd0) ? ID_JALR : ID_NONE;
        CLS_BRANCH: begin
          case (d.f3)
            3'd0:    id = ID_BEQ;
            3'd1:    id = ID_BNE;
            3'd4:    id = ID_BLT;
            3'd5:    id = ID_BGE;
            3'd6:    id = ID_BLTU;
            3'd7:    id = ID_BGEU;
            default: id = ID_NONE;
          endcase
        end
        CLS_LOAD: begin
          case (d.f3)
            3'd0:    id = ID_LB;
            3'd1:    id = ID_LH;
            3'd2:    id = ID_LW;
            3'd4:    id = ID_LBU;
            3'd5:    id = ID_LHU;
            default: id = ID_NONE;
          endcase
        end
        CLS_STORE: begin
          case (d.f3)
            3'd0:    id = ID_SB;
            3'd1:    id = ID_SH;
            3'd2:    id = ID_SW;
            default: id = ID_NONE;
          endcase
        end
        CLS_SYSTEM: begin
          case (d.f3)
            3'd1:    id = ID_CSRRW;
            3'd2:    id = ID_CSRRS;
            3'd3:    id = ID_CSRRC;
            default: id = ID_NONE;
          endcase
        end
        CLS_OPIMM: begin
          case (d.f3)
            3'd0:    id = ID_ADDI;
            3'd1:    id = d.f7_base ? ID_SLLI : ID_NONE;
            3'd2:    id = ID_SLTI;
            3'd3:    id = ID_SLTIU;
            3'd4:    id = ID_XORI;
            3'd5:    id = d.f7_base ? ID_SRLI : (d.f7_alt ? ID_SRAI : ID_NONE);
            3'd6:    id = ID_ORI;
            3'd7:    id = ID_ANDI;
            default: id = ID_NONE;
          endcase
        end
        CLS_OP: begin
          if (d.f7_base) begin
            case (d.f3)
              3'd0:    id = ID_ADD;
              3'd1:    id = ID_SLL;
              3'd2:    id = ID_SLT;
              3'd3:    id = ID_SLTU;
              3'd4:    id = ID_XOR;
              3'd5:    id = ID_SRL;
              3'd6:    id = ID_OR;
              3'd7:    id = ID_AND;
              default: id = ID_NONE;
            endcase
          end else if (d.f7_mul) begin
            case (d.f3)
              3'd0:    id = ID_MUL;
              3'd1:    id = ID_MULH;
              3'd2:    id = ID_MULHSU;
              3'd3:    id = ID_MULHU;
              3'd6:    id = ID_REM;
              default: id = ID_NONE;
            endcase
          end else if (d.f7_alt) begin
            case (d.f3)
              3'd0:    id = ID_SUB;
              3'd5:    id = ID_SRA;
              default: id = ID_NONE;
            endcase
          end
        end
        default: id = ID_NONE;
      endcase
    end
    return id;
  endfunction

endpackage
`default_nettype wire

[src/rvic_field_decode.sv]
`default_nettype none
module rvic_field_decode
  import rvic_pkg::*;
(
  input  wire logic [WORD_W-1:0] word,
  output fields_t                fields
);

  logic [6:0] opc;
  logic [6:0] f7;

  assign opc = word[6:0];
  assign f7  = word[31:25];

  always_comb begin
    fields.is_nop  = (word == WORD_NOP);
    fields.f3      = word[14:12];
    fields.f7_base = (f7 == F7_BASE);
    fields.f7_mul  = (f7 == F7_MUL);
    fields.f7_alt  = (f7 == F7_ALT);
    case (opc)
      OPC_LUI:    fields.cls = CLS_LUI;
      OPC_AUIPC:  fields.cls = CLS_AUIPC;
      OPC_JAL:    fields.cls = CLS_JAL;
      OPC_JALR:   fields.cls = CLS_JALR;
      OPC_BRANCH: fields.cls = CLS_BRANCH;
      OPC_LOAD:   fields.cls = CLS_LOAD;
      OPC_STORE:  fields.cls = CLS_STORE;
      OPC_SYSTEM: fields.cls = CLS_SYSTEM;
      OPC_OPIMM:  fields.cls = CLS_OPIMM;
      OPC_OP:     fields.cls = CLS_OP;
      default:    fields.cls = CLS_NONE;
    endcase
  end

endmodule
`default_nettype wire

[src/rv32im_instruction_classifier_core.sv]
`default_nettype none
// Channel  | Ports                             | Handshake
// ---------+-----------------------------------+------------------------------
// input    | instruction_word                  | start && !busy at clk edge
// result   | recognized, instruction_id        | done, one cycle, no backpressure
//
// One instruction word enters per cycle; busy is never raised.
// The stages are capture, field decode, id lookup.
// Each stage is one register rank with a valid bit alongside the data.
// rst (synchronous) clears the valid bits only; payload is not reset.
// The receiver cannot stall, so the pipeline never holds.
module rv32im_instruction_classifier_core
  import rvic_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [WORD_W-1:0] instruction_word,
  output logic                   done,
  output logic                   recognized,
  output logic [ID_W-1:0]        instruction_id
);

  logic              s1_valid;
  logic [WORD_W-1:0] s1_word;
  logic              s2_valid;
  fields_t           s2_fields;
  fields_t           s2_fields_next;
  logic              s3_valid;
  logic [ID_W-1:0]   s3_id;
  logic [ID_W-1:0]   s3_id_next;

  assign busy = 1'b0;

  rvic_field_decode u_decode (
    .word   (s1_word),
    .fields (s2_fields_next)
  );

  assign s3_id_next = lookup_id(s2_fields);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // advance payload every cycle
  always_ff @(posedge clk) begin
    s1_word   <= instruction_word;
    s2_fields <= s2_fields_next;
    s3_id     <= s3_id_next;
  end

  assign done           = s3_valid;
  assign recognized     = s3_valid && (s3_id != ID_NONE);
  assign instruction_id = s3_valid ? s3_id : ID_NONE;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3)) |-> (done == $past(start, 3)))
    else $error("result strobe does not follow accepted transaction by three cycles");

  a_nop: assert property (@(posedge clk) disable iff (rst)
    ($past(start, 3) && ($past(instruction_word, 3) == WORD_NOP) &&
     !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3))
    |-> (done && recognized && (instruction_id == ID_NOP)))
    else $error("canonical NOP not reported as NOP");

  a_lui: assert property (@(posedge clk) disable iff (rst)
    ($past(start, 3) && ($past(instruction_word[6:0], 3) == OPC_LUI) &&
     !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3))
    |-> (recognized && (instruction_id == ID_LUI)))
    else $error("LUI opcode lost in pipeline");

  a_idle: assert property (@(posedge clk) !done |-> (!recognized && (instruction_id == ID_NONE)))
    else $error("result ports active without strobe");

endmodule
`default_nettype wire

[bench/rv32im_instruction_classifier_core_test.sv]
`timescale 1ns / 1ps

module rv32im_instruction_classifier_core_test;
  import rvic_pkg::*;

  localparam int DIRECTED_MARK = 1500;
  localparam int CALM_FIRST    = 600;
  localparam int CALM_LAST     = 900;
  localparam int DRAIN_CYCLES  = 8;

  localparam logic [6:0] OPC_MISC_MEM = 7'h0f;
  localparam logic [WORD_W-1:0] WORD_ECALL = 32'h0000_0073;

  localparam logic [2:0] F3_ADDSUB = 3'd0;
  localparam logic [2:0] F3_SHL    = 3'd1;
  localparam logic [2:0] F3_SHR    = 3'd5;

  // Per-funct3 id maps; element index is funct3
  localparam logic [7:0][ID_W-1:0] BRANCH_BY_F3 =
    {ID_BGEU, ID_BLTU, ID_BGE, ID_BLT, ID_NONE, ID_NONE, ID_BNE, ID_BEQ};
  localparam logic [7:0][ID_W-1:0] LOAD_BY_F3 =
    {ID_NONE, ID_NONE, ID_LHU, ID_LBU, ID_NONE, ID_LW, ID_LH, ID_LB};
  localparam logic [7:0][ID_W-1:0] STORE_BY_F3 =
    {ID_NONE, ID_NONE, ID_NONE, ID_NONE, ID_NONE, ID_SW, ID_SH, ID_SB};
  localparam logic [7:0][ID_W-1:0] CSR_BY_F3 =
    {ID_NONE, ID_NONE, ID_NONE, ID_NONE, ID_CSRRC, ID_CSRRS, ID_CSRRW, ID_NONE};
  localparam logic [7:0][ID_W-1:0] OPIMM_BY_F3 =
    {ID_ANDI, ID_ORI, ID_NONE, ID_XORI, ID_SLTIU, ID_SLTI, ID_NONE, ID_ADDI};
  localparam logic [7:0][ID_W-1:0] OP_BASE_BY_F3 =
    {ID_AND, ID_OR, ID_SRL, ID_XOR, ID_SLTU, ID_SLT, ID_SLL, ID_ADD};
  localparam logic [7:0][ID_W-1:0] OP_MUL_BY_F3 =
    {ID_NONE, ID_REM, ID_NONE, ID_NONE, ID_MULHU, ID_MULHSU, ID_MULH, ID_MUL};

  localparam logic [9:0][6:0] LISTED_OPCODES =
    {OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH,
     OPC_LOAD, OPC_STORE, OPC_OPIMM, OPC_OP, OPC_SYSTEM};

  typedef struct packed {
    logic            recognized;
    logic [ID_W-1:0] id;
  } decode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [WORD_W-1:0] instruction_word = '0;
  logic              busy;
  logic              done;
  logic              recognized;
  logic [ID_W-1:0]   instruction_id;

  logic [WORD_W-1:0] pending_words[$];
  decode_t           expected_ids[$];
  int                words_sent = 0;
  int                errors = 0;
  int                checked = 0;
  int                recognized_count = 0;
  bit                id_seen[64];

  rv32im_instruction_classifier_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .instruction_word (instruction_word),
    .done             (done),
    .recognized       (recognized),
    .instruction_id   (instruction_id)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [ID_W-1:0] classify_word(input logic [WORD_W-1:0] w);
    logic [6:0]      opc;
    logic [2:0]      f3;
    logic [6:0]      f7;
    logic [ID_W-1:0] id;
    opc = w[6:0];
    f3  = w[14:12];
    f7  = w[31:25];
    id  = ID_NONE;
    if (w == WORD_NOP) begin
      id = ID_NOP;
    end else begin
      case (opc)
        OPC_LUI:    id = ID_LUI;
        OPC_AUIPC:  id = ID_AUIPC;
        OPC_JAL:    id = ID_JAL;
        OPC_JALR:   id = (f3 == F3_ADDSUB) ? ID_JALR : ID_NONE;
        OPC_BRANCH: id = BRANCH_BY_F3[f3];
        OPC_LOAD:   id = LOAD_BY_F3[f3];
        OPC_STORE:  id = STORE_BY_F3[f3];
        OPC_SYSTEM: id = CSR_BY_F3[f3];
        OPC_OPIMM: begin
          if (f3 == F3_SHL) begin
            id = (f7 == F7_BASE) ? ID_SLLI : ID_NONE;
          end else if (f3 == F3_SHR) begin
            if (f7 == F7_BASE) id = ID_SRLI;
            else if (f7 == F7_ALT) id = ID_SRAI;
          end else begin
            id = OPIMM_BY_F3[f3];
          end
        end
        OPC_OP: begin
          if (f7 == F7_BASE) begin
            id = OP_BASE_BY_F3[f3];
          end else if (f7 == F7_MUL) begin
            id = OP_MUL_BY_F3[f3];
          end else if (f7 == F7_ALT) begin
            if (f3 == F3_ADDSUB) id = ID_SUB;
            else if (f3 == F3_SHR) id = ID_SRA;
          end
        end
        default: id = ID_NONE;
      endcase
    end
    return id;
  endfunction

  // Register and immediate fields are filled at random
  function automatic logic [WORD_W-1:0] encode(input logic [6:0] opc, input logic [2:0] f3,
                                               input logic [6:0] f7);
    logic [9:0] rs_bits;
    logic [4:0] rd_bits;
    rs_bits = 10'($urandom);
    rd_bits = 5'($urandom);
    return {f7, rs_bits, f3, rd_bits, opc};
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    int         pick;
    logic [6:0] f7;
    pick = $urandom_range(99);
    if (pick < 2) return WORD_NOP;
    if (pick < 17) return $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3: f7 = F7_BASE;
      4, 5:       f7 = F7_MUL;
      6, 7, 8:    f7 = F7_ALT;
      default:    f7 = 7'($urandom);
    endcase
    return encode(LISTED_OPCODES[$urandom_range(9)], 3'($urandom_range(7)), f7);
  endfunction

  // Driver: push the expectation for each accepted word, then offer the next one
  always @(posedge clk) begin : drive_words
    decode_t exp_entry;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        exp_entry.id = classify_word(instruction_word);
        exp_entry.recognized = (exp_entry.id != ID_NONE);
        expected_ids.push_back(exp_entry);
        words_sent++;
      end
      if (start && busy) begin
        // hold the current transaction
      end else if (pending_words.size() != 0 &&
                   ((words_sent >= CALM_FIRST && words_sent < CALM_LAST) ||
                    $urandom_range(99) >= 23)) begin
        start <= 1'b1;
        instruction_word <= pending_words.pop_front();
      end else begin
        start <= 1'b0;
        instruction_word <= $urandom;
      end
    end
  end

  // Monitor: every strobed result must match the oldest expectation
  always @(posedge clk) begin : check_results
    decode_t exp_entry;
    if (!rst && done === 1'b1) begin
      if (expected_ids.size() == 0) begin
        $display("%0t: unexpected result recognized=%0b id=%0d", $time, recognized,
                 instruction_id);
        errors++;
      end else begin
        exp_entry = expected_ids.pop_front();
        checked++;
        if (recognized !== exp_entry.recognized) begin
          $display("%0t: recognized mismatch, expected %0b actual %0b", $time,
                   exp_entry.recognized, recognized);
          errors++;
        end
        if (instruction_id !== exp_entry.id) begin
          $display("%0t: instruction_id mismatch, expected %0d actual %0d", $time,
                   exp_entry.id, instruction_id);
          errors++;
        end
        if (exp_entry.recognized) recognized_count++;
        id_seen[exp_entry.id] = 1'b1;
      end
    end
  end

  initial begin
    #2ms;
    $display("%0t: timeout with %0d results outstanding", $time, expected_ids.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : main_flow
    int distinct_ids;
    distinct_ids = 0;

    // Extremes, canonical NOP, and listed and unlisted encodings
    pending_words.push_back(WORD_NOP);
    pending_words.push_back(32'h0000_0000);
    pending_words.push_back(32'hffff_ffff);
    pending_words.push_back(32'h0010_0093);
    pending_words.push_back({20'hfffff, 5'h1f, OPC_LUI});
    pending_words.push_back(encode(OPC_AUIPC, 3'($urandom), 7'($urandom)));
    pending_words.push_back(encode(OPC_JAL, 3'($urandom), 7'($urandom)));
    pending_words.push_back(encode(OPC_JALR, F3_ADDSUB, 7'h7f));
    pending_words.push_back(encode(OPC_JALR, F3_SHL, F7_BASE));
    pending_words.push_back(encode(OPC_BRANCH, 3'd0, 7'h40));
    pending_words.push_back(encode(OPC_BRANCH, 3'd7, 7'h3f));
    pending_words.push_back(encode(OPC_BRANCH, 3'd2, F7_BASE));
    pending_words.push_back(encode(OPC_LOAD, 3'd2, 7'h55));
    pending_words.push_back(encode(OPC_LOAD, 3'd3, F7_BASE));
    pending_words.push_back(encode(OPC_STORE, 3'd2, 7'h2a));
    pending_words.push_back(encode(OPC_STORE, 3'd4, F7_BASE));
    pending_words.push_back(encode(OPC_SYSTEM, 3'd1, 7'h7f));
    pending_words.push_back(encode(OPC_SYSTEM, 3'd7, F7_BASE));
    pending_words.push_back(WORD_ECALL);
    pending_words.push_back(encode(OPC_MISC_MEM, 3'd0, F7_BASE));
    pending_words.push_back(encode(OPC_OPIMM, F3_SHR, F7_ALT));
    pending_words.push_back(encode(OPC_OPIMM, F3_SHL, F7_ALT));
    pending_words.push_back(encode(OPC_OP, F3_ADDSUB, F7_ALT));
    pending_words.push_back(encode(OPC_OP, F3_SHR, F7_ALT));
    pending_words.push_back(encode(OPC_OP, 3'd3, F7_MUL));
    pending_words.push_back(encode(OPC_OP, 3'd6, F7_MUL));
    pending_words.push_back(encode(OPC_OP, 3'd4, F7_MUL));
    pending_words.push_back(encode(OPC_OP, 3'd7, F7_MUL));

    while (pending_words.size() < DIRECTED_MARK) begin
      pending_words.push_back(random_word());
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || start || expected_ids.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    for (int i = 0; i < 64; i++) begin
      if (id_seen[i]) distinct_ids++;
    end
    $display("Decoded %0d words: %0d listed, %0d unlisted", checked, recognized_count,
             checked - recognized_count);
    $display("Distinct instruction ids hit (including none): %0d", distinct_ids);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
